FILE: sv/emg_pkg.sv
// ----------------------------------------------------------------------------
// emg_pkg - shared types and constants for the midpoint ellipse generator
// Command codes, sequencer states, multiplier operand selects and the
// control/status structs passed between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package emg_pkg;

	// Default geometry
	localparam int RADIUS_BITS_DEF = 11;
	localparam int COORD_BITS_DEF  = 16;

	// Command codes carried on s_tuser
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ_RX,
		ST_SQ_RY,
		ST_RXRY,
		ST_INIT,
		ST_R2_A,
		ST_R2_B,
		ST_R2_C,
		ST_R2_D,
		ST_R2_E,
		ST_R2_F,
		ST_EMIT
	} st_t;

	// Operand pairs for the shared multiplier
	typedef enum logic [3:0] {
		MOP_NONE,
		MOP_RXRX,
		MOP_RYRY,
		MOP_RXSQ_RY,
		MOP_XX1,
		MOP_RYSQ_P,
		MOP_YM1SQ,
		MOP_RXSQ_P,
		MOP_RXSQ_RYSQ
	} mop_t;

	// Sequencer to datapath
	typedef struct packed {
		logic ready;
		logic emit;
		mop_t mop;
		logic ld_rx_sq;
		logic ld_ry_sq;
		logic ld_init;
		logic acc_first;
		logic acc_add;
		logic set_r2;
		logic ld_dec_r2;
	} ctl_t;

	// Datapath to sequencer
	typedef struct packed {
		logic active;
		logic region_two;
		logic dx_lt_dy;
		logic y_neg;
		logic pt_last;
	} sts_t;

endpackage

FILE: sv/midpoint_ellipse_point_generator_top.sv
// ----------------------------------------------------------------------------
// midpoint_ellipse_point_generator_top - midpoint ellipse outline rasterizer
// Start items load a centre and radii; step items emit four mirror points.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): s_tuser is the command, 0 starts a new ellipse from
//   the centre and radii in s_tdata, 1 runs one iteration of the outline.
//   Output stream (m_*): one point per transfer, four per step in the order
//   (+x,+y) (-x,+y) (+x,-y) (-x,-y); m_tlast marks the fourth point and
//   m_tuser is set on all four points of the step that closes the ellipse.
// Sequencing:
//   s_tready returns after a start transfer once the sequencer has passed
//   SQ_RX, SQ_RY, RXRY and INIT: three passes through the shared multiplier
//   and one state to set the terms. A step then emits its four points, one
//   point per cycle while m_tready is high. The step that enters region two
//   first forms the new decision term in the multiplier in R2_A to R2_E and
//   loads it in R2_F. A step with no ellipse running produces nothing.
// Reset and stall:
//   Reset leaves the block idle with no ellipse running. s_tready is low
//   from a transfer until all its points are taken; a stalled receiver
//   simply holds the current point on m_tdata.
// ----------------------------------------------------------------------------
module midpoint_ellipse_point_generator_top #(
	parameter int RADIUS_BITS = emg_pkg::RADIUS_BITS_DEF,
	parameter int COORD_BITS  = emg_pkg::COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	// input stream
	input  logic s_tvalid,
	output logic s_tready,
	// centre x, centre y, x radius, y radius
	input  logic [((2*COORD_BITS+2*RADIUS_BITS+7)/8)*8-1:0] s_tdata,
	// cmd
	input  logic s_tuser,
	// output stream
	output logic m_tvalid,
	input  logic m_tready,
	// point_x, point_y
	output logic [((2*(COORD_BITS+1)+7)/8)*8-1:0] m_tdata,
	// last_of_step
	output logic m_tlast,
	// final_step
	output logic m_tuser
);
	import emg_pkg::*;

	localparam int R     = RADIUS_BITS;
	localparam int C     = COORD_BITS;
	localparam int PW    = C + 1;
	localparam int XW    = R + 1;
	localparam int YW    = R + 2;
	localparam int SQW   = 2 * R;
	localparam int SW    = 3 * R + 3;
	localparam int DW    = 4 * R + 8;
	localparam int AW    = 2 * R + 4;
	localparam int BW    = 2 * R;
	localparam int MW    = AW + BW;
	localparam int EW    = ((C > YW) ? C : YW) + 2;
	localparam int OUT_TW = ((2 * PW + 7) / 8) * 8;

	ctl_t ctl;
	sts_t sts;

	// control state
	logic       active_q;
	logic       r2_q;
	logic [1:0] pt_q;

	// geometry and decision terms
	logic [C-1:0]   cx_q;
	logic [C-1:0]   cy_q;
	logic [R-1:0]   rx_q;
	logic [R-1:0]   ry_q;
	logic [SQW-1:0] rx_sq_q;
	logic [SQW-1:0] ry_sq_q;
	logic [XW-1:0]  x_q;
	logic [YW-1:0]  y_q;
	logic [SW-1:0]  dx_q;
	logic [SW-1:0]  dy_q;
	logic [DW-1:0]  dec_q;
	logic [DW-1:0]  acc_q;

	// multiplier
	logic [AW-1:0] mul_a;
	logic [BW-1:0] mul_b;
	logic [MW-1:0] prod_q;

	// handshake decode
	logic in_xfer;
	logic start;
	logic step_drop;
	logic drop;
	logic out_xfer;
	logic emit_done;
	logic fin;

	// step update terms
	logic [SW-1:0]  ry2;
	logic [SW-1:0]  rx2;
	logic [SW-1:0]  dx_inc;
	logic [SW-1:0]  dy_dec;
	logic [DW-1:0]  dx_inc_ext;
	logic [DW-1:0]  dy_dec_ext;
	logic [XW-1:0]  x_n;
	logic [YW-1:0]  y_n;
	logic [SW-1:0]  dx_n;
	logic [SW-1:0]  dy_n;
	logic [DW-1:0]  dec_n;
	logic [DW-1:0]  init_dec;
	logic [DW-1:0]  r2_sum;
	logic [DW-1:0]  r2_dec;
	logic [YW:0]    ym1;
	logic [YW:0]    ym1_abs;

	// point terms
	logic [EW-1:0] ext_cx;
	logic [EW-1:0] ext_cy;
	logic [EW-1:0] ext_x;
	logic [EW-1:0] ext_y;
	logic [EW-1:0] px;
	logic [EW-1:0] py;

	emg_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.cmd      (s_tuser),
		.m_tready (m_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	emg_mult #(
		.AW (AW),
		.BW (BW)
	) u_mult (
		.clk    (clk),
		.en     (ctl.mop != MOP_NONE),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	// handshakes
	assign s_tready  = ctl.ready;
	assign in_xfer   = s_tvalid && ctl.ready;
	assign start     = in_xfer && (s_tuser == CMD_START);
	assign step_drop = in_xfer && (s_tuser == CMD_STEP) && active_q && r2_q && y_q[YW-1];
	assign drop      = step_drop || (ctl.ld_dec_r2 && y_q[YW-1]);
	assign m_tvalid  = ctl.emit;
	assign out_xfer  = ctl.emit && m_tready;
	assign emit_done = out_xfer && (pt_q == 2'd3);
	assign fin       = r2_q && (y_q == '0);

	// status to sequencer
	always_comb begin
		sts.active     = active_q;
		sts.region_two = r2_q;
		sts.dx_lt_dy   = $signed(dx_q) < $signed(dy_q);
		sts.y_neg      = y_q[YW-1];
		sts.pt_last    = (pt_q == 2'd3);
	end

	// multiplier operand select
	assign ym1     = {y_q[YW-1], y_q} - (YW+1)'(1);
	assign ym1_abs = ym1[YW] ? ((YW+1)'(0) - ym1) : ym1;

	always_comb begin
		unique case (ctl.mop)
			MOP_RXRX: begin
				mul_a = AW'(rx_q);
				mul_b = BW'(rx_q);
			end
			MOP_RYRY: begin
				mul_a = AW'(ry_q);
				mul_b = BW'(ry_q);
			end
			MOP_RXSQ_RY: begin
				mul_a = AW'(ry_q);
				mul_b = rx_sq_q;
			end
			MOP_XX1: begin
				mul_a = AW'(x_q) + AW'(1);
				mul_b = BW'(x_q);
			end
			MOP_RYSQ_P: begin
				mul_a = prod_q[AW-1:0];
				mul_b = ry_sq_q;
			end
			MOP_YM1SQ: begin
				mul_a = AW'(ym1_abs);
				mul_b = BW'(ym1_abs);
			end
			MOP_RXSQ_P: begin
				mul_a = prod_q[AW-1:0];
				mul_b = rx_sq_q;
			end
			MOP_RXSQ_RYSQ: begin
				mul_a = AW'(ry_sq_q);
				mul_b = rx_sq_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// start and region-switch decision terms
	assign init_dec = DW'(ry_sq_q) - DW'(prod_q) + DW'(rx_sq_q >> 2);
	assign r2_sum   = acc_q - DW'(prod_q) + DW'(ry_sq_q >> 2);
	// truncate toward zero: a negative value with a fraction rounds up
	assign r2_dec   = ((ry_sq_q[1:0] != 2'b00) && r2_sum[DW-1]) ? r2_sum + DW'(1) : r2_sum;

	// one loop iteration, applied after the fourth point is taken
	assign ry2        = {ry_sq_q, 1'b0};
	assign rx2        = {rx_sq_q, 1'b0};
	assign dx_inc     = dx_q + ry2;
	assign dy_dec     = dy_q - rx2;
	assign dx_inc_ext = {{(DW-SW){dx_inc[SW-1]}}, dx_inc};
	assign dy_dec_ext = {{(DW-SW){dy_dec[SW-1]}}, dy_dec};

	always_comb begin
		x_n   = x_q;
		y_n   = y_q;
		dx_n  = dx_q;
		dy_n  = dy_q;
		dec_n = dec_q;
		if (!r2_q) begin
			x_n  = x_q + XW'(1);
			dx_n = dx_inc;
			if (dec_q[DW-1]) begin
				dec_n = dec_q + dx_inc_ext + DW'(ry_sq_q);
			end else begin
				y_n   = y_q - YW'(1);
				dy_n  = dy_dec;
				dec_n = dec_q + dx_inc_ext - dy_dec_ext + DW'(ry_sq_q);
			end
		end else begin
			y_n  = y_q - YW'(1);
			dy_n = dy_dec;
			if (!dec_q[DW-1] && (dec_q != '0)) begin
				dec_n = dec_q + DW'(rx_sq_q) - dy_dec_ext;
			end else begin
				x_n   = x_q + XW'(1);
				dx_n  = dx_inc;
				dec_n = dec_q + dx_inc_ext - dy_dec_ext + DW'(rx_sq_q);
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			r2_q     <= 1'b0;
			pt_q     <= 2'd0;
		end else begin
			if (start) begin
				active_q <= 1'b1;
				r2_q     <= 1'b0;
			end else begin
				if (ctl.set_r2) begin
					r2_q <= 1'b1;
				end
				if (drop || (emit_done && fin)) begin
					active_q <= 1'b0;
				end
			end
			if (out_xfer) begin
				pt_q <= pt_q + 2'd1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (start) begin
			cx_q <= s_tdata[C-1:0];
			cy_q <= s_tdata[2*C-1:C];
			rx_q <= s_tdata[2*C+R-1:2*C];
			ry_q <= s_tdata[2*C+2*R-1:2*C+R];
			x_q  <= '0;
			y_q  <= YW'(s_tdata[2*C+2*R-1:2*C+R]);
			dx_q <= '0;
		end
		if (ctl.ld_rx_sq) begin
			rx_sq_q <= prod_q[SQW-1:0];
		end
		if (ctl.ld_ry_sq) begin
			ry_sq_q <= prod_q[SQW-1:0];
		end
		if (ctl.ld_init) begin
			dy_q  <= {prod_q[SW-2:0], 1'b0};
			dec_q <= init_dec;
		end
		if (ctl.acc_first) begin
			acc_q <= DW'(prod_q);
		end else if (ctl.acc_add) begin
			acc_q <= acc_q + DW'(prod_q);
		end
		if (ctl.ld_dec_r2) begin
			dec_q <= r2_dec;
		end
		if (emit_done) begin
			x_q   <= x_n;
			y_q   <= y_n;
			dx_q  <= dx_n;
			dy_q  <= dy_n;
			dec_q <= dec_n;
		end
	end

	// mirror points: bit 0 of the count negates x, bit 1 negates y
	assign ext_cx = {{(EW-C){cx_q[C-1]}}, cx_q};
	assign ext_cy = {{(EW-C){cy_q[C-1]}}, cy_q};
	assign ext_x  = {{(EW-XW){1'b0}}, x_q};
	assign ext_y  = {{(EW-YW){y_q[YW-1]}}, y_q};
	assign px     = pt_q[0] ? (ext_cx - ext_x) : (ext_cx + ext_x);
	assign py     = pt_q[1] ? (ext_cy - ext_y) : (ext_cy + ext_y);

	assign m_tdata = OUT_TW'({py[PW-1:0], px[PW-1:0]});
	assign m_tlast = (pt_q == 2'd3);
	assign m_tuser = fin;

	// the block never takes an item while a point is on offer
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while a point is pending");

	// a start keeps the input closed while the terms are formed
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == CMD_START)) |=> !s_tready)
		else $error("input reopened during start sequence");

	// the closing step ends the ellipse
	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast && m_tuser) |=> !active_q)
		else $error("ellipse still running after final step");

	// only a start brings the generator out of idle
	a_active_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(active_q) |-> $past(s_tvalid && s_tready && (s_tuser == CMD_START)))
		else $error("generator became active without a start");

endmodule

FILE: sv/emg_mult.sv
// ----------------------------------------------------------------------------
// emg_mult - shared unsigned multiplier
// One registered product per enabled cycle; used for every square and
// cross term of the start and region-switch sequences.
// ----------------------------------------------------------------------------
module emg_mult #(
	parameter int AW = 26,
	parameter int BW = 22
) (
	input  logic             clk,
	input  logic             en,
	input  logic [AW-1:0]    a,
	input  logic [BW-1:0]    b,
	output logic [AW+BW-1:0] prod_q
);
	localparam int MW = AW + BW;

	// registered product
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= MW'(a) * MW'(b);
		end
	end

endmodule

FILE: sv/emg_seq.sv
// ----------------------------------------------------------------------------
// emg_seq - sequencer for the midpoint ellipse generator
// Steps the shared multiplier through the start and region-switch
// sequences and holds the block in the emit state for four point transfers.
// ----------------------------------------------------------------------------
module emg_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	input  logic          cmd,
	input  logic          m_tready,
	input  emg_pkg::sts_t sts,
	output emg_pkg::ctl_t ctl
);
	import emg_pkg::*;

	st_t state_q;
	st_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					priority if (cmd == CMD_START) begin
						state_d = ST_SQ_RX;
					end else if (!sts.active) begin
						state_d = ST_IDLE;
					end else if (!sts.region_two && !sts.dx_lt_dy) begin
						state_d = ST_R2_A;
					end else if (sts.region_two && sts.y_neg) begin
						state_d = ST_IDLE;
					end else begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_SQ_RX: state_d = ST_SQ_RY;
			ST_SQ_RY: state_d = ST_RXRY;
			ST_RXRY:  state_d = ST_INIT;
			ST_INIT:  state_d = ST_IDLE;
			ST_R2_A:  state_d = ST_R2_B;
			ST_R2_B:  state_d = ST_R2_C;
			ST_R2_C:  state_d = ST_R2_D;
			ST_R2_D:  state_d = ST_R2_E;
			ST_R2_E:  state_d = ST_R2_F;
			ST_R2_F:  state_d = sts.y_neg ? ST_IDLE : ST_EMIT;
			ST_EMIT: begin
				if (m_tready && sts.pt_last) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs decoded from state
	always_comb begin
		ctl = '0;
		ctl.mop = MOP_NONE;
		unique case (state_q)
			ST_IDLE:  ctl.ready = 1'b1;
			ST_SQ_RX: ctl.mop = MOP_RXRX;
			ST_SQ_RY: begin
				ctl.ld_rx_sq = 1'b1;
				ctl.mop      = MOP_RYRY;
			end
			ST_RXRY: begin
				ctl.ld_ry_sq = 1'b1;
				ctl.mop      = MOP_RXSQ_RY;
			end
			ST_INIT:  ctl.ld_init = 1'b1;
			ST_R2_A: begin
				ctl.set_r2 = 1'b1;
				ctl.mop    = MOP_XX1;
			end
			ST_R2_B:  ctl.mop = MOP_RYSQ_P;
			ST_R2_C: begin
				ctl.acc_first = 1'b1;
				ctl.mop       = MOP_YM1SQ;
			end
			ST_R2_D:  ctl.mop = MOP_RXSQ_P;
			ST_R2_E: begin
				ctl.acc_add = 1'b1;
				ctl.mop     = MOP_RXSQ_RYSQ;
			end
			ST_R2_F:  ctl.ld_dec_r2 = 1'b1;
			ST_EMIT:  ctl.emit = 1'b1;
			default:  ctl.ready = 1'b0;
		endcase
	end

endmodule
